>>> rtl/segment_tree_point_add_range_sum_defines.svh
// Assertion macros used by the top module to check the tree logic.
`ifndef SEGMENT_TREE_POINT_ADD_RANGE_SUM_DEFINES_SVH
`define SEGMENT_TREE_POINT_ADD_RANGE_SUM_DEFINES_SVH

// Check that a condition holds in the same cycle as its trigger.
`define SEGTREE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition holds in the cycle after its trigger.
`define SEGTREE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/segtree_pkg.sv
`timescale 1ns / 1ps

package segtree_pkg;

    // Default geometry of the tree
    localparam int MAX_SIZE_DEF    = 1024;
    localparam int VALUE_WIDTH_DEF = 32;

    // Fixed widths of the item fields
    localparam int OPCODE_W = 2;
    localparam int POS_W    = 10;
    localparam int CFG_W    = 11;
    localparam int IO_VAL_W = 32;

    // Item operations; code 3 means nothing and is dropped
    typedef enum logic [OPCODE_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_ADD   = 2'd1,
        OP_QUERY = 2'd2
    } op_t;

    // Control fields of one item handed to the engine
    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [POS_W-1:0]    position;
        logic [POS_W-1:0]    range_low;
        logic [POS_W-1:0]    range_high;
    } cmd_t;

endpackage

>>> rtl/segtree_ram.sv
`timescale 1ns / 1ps

module segtree_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write one entry, read one entry with a registered output
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/segtree_engine.sv
`timescale 1ns / 1ps

module segtree_engine #(
    parameter int MAX_SIZE    = segtree_pkg::MAX_SIZE_DEF,
    parameter int VALUE_WIDTH = segtree_pkg::VALUE_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  segtree_pkg::cmd_t              cmd,
    input  logic [VALUE_WIDTH-1:0]         cmd_value,
    input  logic [$clog2(MAX_SIZE+1)-1:0]  size,
    output logic                           busy,
    output logic                           res_valid,
    output logic [VALUE_WIDTH-1:0]         res_sum
);

    localparam int DEPTH  = 2 * MAX_SIZE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int NODE_W = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LEAF,
        S_UP,
        S_QA,
        S_QB
    } state_t;

    state_t                 state_reg, state_next;
    logic [ADDR_W-1:0]      clr_reg, clr_next;
    logic [ADDR_W-1:0]      node_reg, node_next;
    logic [VALUE_WIDTH-1:0] cur_reg, cur_next;
    logic [VALUE_WIDTH-1:0] val_reg, val_next;
    logic [NODE_W-1:0]      a_reg, a_next;
    logic [NODE_W-1:0]      b_reg, b_next;
    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;
    logic                   pend_reg, pend_next;
    logic                   res_valid_reg, res_valid_next;
    logic [VALUE_WIDTH-1:0] res_sum_reg, res_sum_next;

    logic                   rd_en, wr_en;
    logic [ADDR_W-1:0]      rd_addr, wr_addr;
    logic [VALUE_WIDTH-1:0] rd_data, wr_data;

    logic [31:0]            pos_w, lo_w, hi_w, size_w;
    logic                   q_empty;
    logic [ADDR_W-1:0]      leaf, parent;
    logic [VALUE_WIDTH-1:0] acc_eff, node_sum;
    logic [NODE_W-1:0]      b_dec;

    segtree_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Decode the item: leaf node and clipped query bounds
    always_comb
    begin
        pos_w  = 32'(cmd.position);
        lo_w   = 32'(cmd.range_low);
        size_w = 32'(size);
        hi_w   = 32'(cmd.range_high);
        if (hi_w >= size_w)
        begin
            hi_w = size_w - 32'd1;
        end
        q_empty = (lo_w > hi_w) || (lo_w >= size_w);
        leaf    = ADDR_W'(pos_w + 32'(MAX_SIZE));
        parent  = node_reg >> 1;
        acc_eff = acc_reg + (pend_reg ? rd_data : '0);
        b_dec   = b_reg[0] ? (b_reg - NODE_W'(1)) : b_reg;
    end

    // Sequence memory accesses and the walk over the tree
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        node_next      = node_reg;
        cur_next       = cur_reg;
        val_next       = val_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        acc_next       = acc_reg;
        pend_next      = 1'b0;
        res_valid_next = 1'b0;
        res_sum_next   = res_sum_reg;
        rd_en          = 1'b0;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = '0;
        node_sum       = '0;

        case (state_reg)
            S_CLEAR:
            begin
                // Sweep zeros through the store after reset
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                clr_next = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    if ((cmd.opcode == segtree_pkg::OP_LOAD ||
                         cmd.opcode == segtree_pkg::OP_ADD) && pos_w < size_w)
                    begin
                        node_next = leaf;
                        val_next  = cmd_value;
                        if (cmd.opcode == segtree_pkg::OP_LOAD)
                        begin
                            // Overwrite the leaf and fetch its sibling
                            wr_en      = 1'b1;
                            wr_addr    = leaf;
                            wr_data    = cmd_value;
                            cur_next   = cmd_value;
                            rd_en      = 1'b1;
                            rd_addr    = leaf ^ ADDR_W'(1);
                            state_next = S_UP;
                        end
                        else
                        begin
                            // Fetch the leaf to add to
                            rd_en      = 1'b1;
                            rd_addr    = leaf;
                            state_next = S_LEAF;
                        end
                    end
                    else if (cmd.opcode == segtree_pkg::OP_QUERY)
                    begin
                        if (q_empty)
                        begin
                            res_valid_next = 1'b1;
                            res_sum_next   = '0;
                        end
                        else
                        begin
                            a_next     = NODE_W'(lo_w + 32'(MAX_SIZE));
                            b_next     = NODE_W'(hi_w + 32'(MAX_SIZE) + 32'd1);
                            acc_next   = '0;
                            state_next = S_QA;
                        end
                    end
                end
            end

            S_LEAF:
            begin
                // Write the new leaf and fetch its sibling
                node_sum   = rd_data + val_reg;
                wr_en      = 1'b1;
                wr_addr    = node_reg;
                wr_data    = node_sum;
                cur_next   = node_sum;
                rd_en      = 1'b1;
                rd_addr    = node_reg ^ ADDR_W'(1);
                state_next = S_UP;
            end

            S_UP:
            begin
                // Refresh the parent, then, unless it is the root, fetch the parent's sibling
                node_sum  = cur_reg + rd_data;
                wr_en     = 1'b1;
                wr_addr   = parent;
                wr_data   = node_sum;
                cur_next  = node_sum;
                node_next = parent;
                if (parent == ADDR_W'(1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = parent ^ ADDR_W'(1);
                end
            end

            S_QA:
            begin
                // Left edge of the range at this level, or strobe the sum once the edges meet
                acc_next = acc_eff;
                if (a_reg >= b_reg)
                begin
                    res_valid_next = 1'b1;
                    res_sum_next   = acc_eff;
                    state_next     = S_IDLE;
                end
                else
                begin
                    if (a_reg[0])
                    begin
                        rd_en     = 1'b1;
                        rd_addr   = a_reg[ADDR_W-1:0];
                        pend_next = 1'b1;
                        a_next    = a_reg + NODE_W'(1);
                    end
                    state_next = S_QB;
                end
            end

            S_QB:
            begin
                // Right edge of the range, then climb one level
                acc_next = acc_eff;
                if (b_reg[0])
                begin
                    rd_en     = 1'b1;
                    rd_addr   = b_dec[ADDR_W-1:0];
                    pend_next = 1'b1;
                end
                a_next     = a_reg >> 1;
                b_next     = b_dec >> 1;
                state_next = S_QA;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            pend_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            pend_reg      <= pend_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg    <= node_next;
        cur_reg     <= cur_next;
        val_reg     <= val_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        acc_reg     <= acc_next;
        res_sum_reg <= res_sum_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;
    assign res_sum   = res_sum_reg;

endmodule

>>> rtl/segment_tree_point_add_range_sum.sv
`timescale 1ns / 1ps
//  Channel   Signals                                          Handshake
//  input     opcode position value range_low range_high       start & !busy
//  result    range_sum                                        result_valid, one cycle
//  config    cfg_data                                         cfg_write
//
//  Load writes the leaf, then walks from leaf to root, rewriting each parent as
//  the sum of its children; add first reads the leaf to add the value to it.
//  Query walks up both edges of the range level by level, reading at most one
//  node per state; the sum is strobed as busy falls.
//  Dropped items and empty queries leave busy low; an empty query strobes zero.
//  After reset a clearing pass over all 2*MAX_SIZE entries holds busy high.
//  Results cannot be stalled; busy alone paces incoming items.

`include "segment_tree_point_add_range_sum_defines.svh"

module segment_tree_point_add_range_sum #(
    parameter int MAX_SIZE    = segtree_pkg::MAX_SIZE_DEF,
    parameter int VALUE_WIDTH = segtree_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic [segtree_pkg::OPCODE_W-1:0]        opcode,
    input  logic [segtree_pkg::POS_W-1:0]           position,
    input  logic signed [segtree_pkg::IO_VAL_W-1:0] value,
    input  logic [segtree_pkg::POS_W-1:0]           range_low,
    input  logic [segtree_pkg::POS_W-1:0]           range_high,
    output logic                                    result_valid,
    output logic signed [segtree_pkg::IO_VAL_W-1:0] range_sum,
    input  logic                                    cfg_write,
    input  logic [segtree_pkg::CFG_W-1:0]           cfg_data
);

    localparam int SIZE_W = $clog2(MAX_SIZE + 1);

    logic [SIZE_W-1:0]             size_reg, size_next;
    segtree_pkg::cmd_t             cmd;
    logic [VALUE_WIDTH-1:0]        cmd_value;
    logic signed [VALUE_WIDTH-1:0] res_sum;

    // Clamp the size written into the range 1 to MAX_SIZE
    always_comb
    begin
        size_next = size_reg;
        if (cfg_write)
        begin
            if (cfg_data == '0)
            begin
                size_next = SIZE_W'(1);
            end
            else if (32'(cfg_data) > 32'(MAX_SIZE))
            begin
                size_next = SIZE_W'(MAX_SIZE);
            end
            else
            begin
                size_next = SIZE_W'(cfg_data);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_W'(MAX_SIZE);
        end
        else
        begin
            size_reg <= size_next;
        end
    end

    // Pack the item and bring the value to the tree width
    assign cmd.opcode     = opcode;
    assign cmd.position   = position;
    assign cmd.range_low  = range_low;
    assign cmd.range_high = range_high;
    assign cmd_value      = VALUE_WIDTH'(value);

    segtree_engine #(
        .MAX_SIZE    (MAX_SIZE),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .cmd_value (cmd_value),
        .size      (size_reg),
        .busy      (busy),
        .res_valid (result_valid),
        .res_sum   (res_sum)
    );

    // Sign-extend or truncate the sum to the result width
    assign range_sum = segtree_pkg::IO_VAL_W'(res_sum);

    `SEGTREE_ASSERT_NEXT(a_update_silent, start && !busy && opcode != segtree_pkg::OP_QUERY, !result_valid, "load or add item produced a result")
    `SEGTREE_ASSERT_NEXT(a_query_progress, start && !busy && opcode == segtree_pkg::OP_QUERY, busy || result_valid, "query item neither walked nor answered")
    `SEGTREE_ASSERT_SAME(a_result_idle, result_valid, !busy, "result shown while the walk is still running")

endmodule

>>> verif/segment_tree_point_add_range_sum_tb.sv
`timescale 1ns / 1ps

module segment_tree_point_add_range_sum_tb;

    localparam int          OPCODE_W    = segtree_pkg::OPCODE_W;
    localparam int          POS_W       = segtree_pkg::POS_W;
    localparam int          CFG_W       = segtree_pkg::CFG_W;
    localparam int          IO_VAL_W    = segtree_pkg::IO_VAL_W;
    localparam int          LEAVES      = segtree_pkg::MAX_SIZE_DEF;
    localparam int          CYCLE_LIMIT = 600000;
    localparam int          DRAIN_WAIT  = 50;
    localparam logic [1:0]  OP_NONE     = 2'd3;

    // Keep a flat copy of the leaves and the expected query sums in order
    class range_sum_board;
        logic [IO_VAL_W-1:0] leaf_vals [LEAVES];
        int unsigned         live_size;
        logic [IO_VAL_W-1:0] pending_sums [$];
        int                  errors;
        int                  n_checked;
        int                  n_updates;

        function new();
            foreach (leaf_vals[i])
                leaf_vals[i] = '0;
            live_size = LEAVES;
            errors    = 0;
            n_checked = 0;
            n_updates = 0;
        endfunction

        // Clamp a written size to 1 .. LEAVES
        function void note_size(logic [CFG_W-1:0] raw);
            int unsigned v;
            v = raw;
            if (v == 0)
                v = 1;
            if (v > LEAVES)
                v = LEAVES;
            live_size = v;
        endfunction

        // Apply an accepted item and queue the sum a query must return
        function void note_item(logic [OPCODE_W-1:0] op, logic [POS_W-1:0] pos,
                                logic [IO_VAL_W-1:0] val, logic [POS_W-1:0] lo,
                                logic [POS_W-1:0] hi);
            logic [IO_VAL_W-1:0] acc;
            int unsigned         top;
            acc = '0;
            top = hi;
            if (op == segtree_pkg::OP_LOAD || op == segtree_pkg::OP_ADD) begin
                if (pos < live_size) begin
                    if (op == segtree_pkg::OP_LOAD)
                        leaf_vals[pos] = val;
                    else
                        leaf_vals[pos] = leaf_vals[pos] + val;
                    n_updates++;
                end
            end
            else if (op == segtree_pkg::OP_QUERY) begin
                if (top >= live_size)
                    top = live_size - 1;
                if (lo <= top && lo < live_size)
                    for (int i = lo; i <= top; i++)
                        acc = acc + leaf_vals[i];
                pending_sums.insert(pending_sums.size(), acc);
            end
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        task check_sum(logic [IO_VAL_W-1:0] got);
            logic [IO_VAL_W-1:0] want;
            if (pending_sums.size() == 0) begin
                report($sformatf("range_sum %h with no query outstanding", got));
            end
            else begin
                want = pending_sums.pop_front();
                n_checked++;
                if (got !== want)
                    report($sformatf("range_sum got %h want %h", got, want));
            end
        endtask
    endclass

    logic                clk;
    logic                rst_n      = 1'b0;
    logic                start      = 1'b0;
    logic                busy;
    logic [OPCODE_W-1:0] opcode     = '0;
    logic [POS_W-1:0]    position   = '0;
    logic [IO_VAL_W-1:0] value      = '0;
    logic [POS_W-1:0]    range_low  = '0;
    logic [POS_W-1:0]    range_high = '0;
    logic                result_valid;
    logic [IO_VAL_W-1:0] range_sum;
    logic                cfg_write  = 1'b0;
    logic [CFG_W-1:0]    cfg_data   = '0;

    range_sum_board board;
    bit             no_idle    = 1'b0;
    int             n_settings = 0;
    int             cycles     = 0;

    segment_tree_point_add_range_sum dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .position     (position),
        .value        (value),
        .range_low    (range_low),
        .range_high   (range_high),
        .result_valid (result_valid),
        .range_sum    (range_sum),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Check every strobed sum against the oldest outstanding query
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            board.check_sum(range_sum);
    end

    // Stop a hung run
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("** segment_tree_point_add_range_sum: FAILED **");
        $finish;
    end

    // Present one item after a random gap and hold it until accepted
    task automatic send_item(logic [OPCODE_W-1:0] op, logic [POS_W-1:0] pos,
                             logic [IO_VAL_W-1:0] val, logic [POS_W-1:0] lo,
                             logic [POS_W-1:0] hi);
        int gap;
        if ($urandom_range(0, 39) == 0)
            no_idle = !no_idle;
        gap = no_idle ? 0 : $urandom_range(0, 13);
        repeat (gap)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start      <= 1'b1;
        opcode     <= op;
        position   <= pos;
        value      <= val;
        range_low  <= lo;
        range_high <= hi;
        do
            @(posedge clk);
        while (busy);
        board.note_item(op, pos, val, lo, hi);
    endtask

    // Let the block drain, then write the size register
    task automatic set_size(logic [CFG_W-1:0] raw);
        @(negedge clk);
        start <= 1'b0;
        while (board.pending_sums.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= raw;
        @(negedge clk);
        cfg_write <= 1'b0;
        board.note_size(raw);
        n_settings++;
    endtask

    function automatic logic [IO_VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'hffff_ffff;
            3, 4:    return $urandom_range(0, 255) - 128;
            default: return $urandom;
        endcase
    endfunction

    // Draw one item shaped by the size in use
    task automatic random_item();
        int unsigned         sz;
        int unsigned         sel;
        logic [OPCODE_W-1:0] op;
        logic [POS_W-1:0]    pos;
        logic [POS_W-1:0]    lo;
        logic [POS_W-1:0]    hi;
        sz  = board.live_size;
        sel = $urandom_range(0, 99);
        pos = ($urandom_range(0, 99) < 85) ? $urandom_range(0, sz - 1) : $urandom_range(0, 1023);
        lo  = $urandom_range(0, 1023);
        hi  = $urandom_range(0, 1023);
        if (sel < 30)
            op = segtree_pkg::OP_LOAD;
        else if (sel < 55)
            op = segtree_pkg::OP_ADD;
        else if (sel < 95)
            op = segtree_pkg::OP_QUERY;
        else
            op = OP_NONE;
        if (op == segtree_pkg::OP_QUERY) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                begin
                    lo = $urandom_range(0, sz - 1);
                    hi = $urandom_range(lo, sz - 1);
                end
                7:
                begin
                    hi = $urandom_range(0, 1022);
                    lo = $urandom_range(hi + 1, 1023);
                end
                8:
                begin
                    if (sz < LEAVES)
                        lo = $urandom_range(sz, 1023);
                end
                9:
                begin
                    lo = '0;
                    hi = '1;
                end
                default: ;
            endcase
        end
        send_item(op, pos, pick_value(), lo, hi);
    endtask

    initial
    begin
        logic [CFG_W-1:0] phase_sizes [10];
        board = new();
        phase_sizes = '{11'd1, 11'd2, 11'd0, 11'd2047, 11'd37,
                        11'd513, 11'd1023, 11'd200, 11'd1024, 11'd1024};
        phase_sizes[8] = $urandom_range(3, 1023);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Extremes at the reset size, with wraps, reversed range and the unused code
        send_item(segtree_pkg::OP_LOAD,  10'd0,    32'h7fff_ffff, 10'd0,   10'd0);
        send_item(segtree_pkg::OP_LOAD,  10'd1023, 32'h8000_0000, 10'd0,   10'd0);
        send_item(segtree_pkg::OP_QUERY, 10'd0,    32'h0,         10'd0,   10'd1023);
        send_item(segtree_pkg::OP_ADD,   10'd0,    32'h0000_0001, 10'd0,   10'd0);
        send_item(segtree_pkg::OP_QUERY, 10'd0,    32'h0,         10'd0,   10'd0);
        send_item(segtree_pkg::OP_QUERY, 10'd0,    32'h0,         10'd1023, 10'd1023);
        send_item(segtree_pkg::OP_QUERY, 10'd0,    32'h0,         10'd0,   10'd1023);
        send_item(segtree_pkg::OP_ADD,   10'd1023, 32'hffff_ffff, 10'd0,   10'd0);
        send_item(segtree_pkg::OP_QUERY, 10'd0,    32'h0,         10'd5,   10'd3);
        send_item(OP_NONE,               10'd0,    32'd12345,     10'd0,   10'd1023);
        send_item(segtree_pkg::OP_QUERY, 10'd0,    32'h0,         10'd0,   10'd0);
        send_item(segtree_pkg::OP_LOAD,  10'd512,  32'h5555_5555, 10'd0,   10'd0);
        send_item(segtree_pkg::OP_LOAD,  10'd511,  32'haaaa_aaaa, 10'd0,   10'd0);
        send_item(segtree_pkg::OP_QUERY, 10'd0,    32'h0,         10'd511, 10'd512);
        send_item(segtree_pkg::OP_QUERY, 10'd0,    32'h0,         10'd1,   10'd1022);
        send_item(segtree_pkg::OP_LOAD,  10'd0,    32'h0,         10'd0,   10'd0);

        // Small size: writes past the end dropped, ranges clipped or empty
        set_size(11'd8);
        send_item(segtree_pkg::OP_LOAD,  10'd8,    32'h0000_0001, 10'd0,   10'd0);
        send_item(segtree_pkg::OP_LOAD,  10'd7,    32'h0000_0009, 10'd0,   10'd0);
        send_item(segtree_pkg::OP_QUERY, 10'd0,    32'h0,         10'd0,   10'd1023);
        send_item(segtree_pkg::OP_QUERY, 10'd0,    32'h0,         10'd8,   10'd9);
        send_item(segtree_pkg::OP_ADD,   10'd1023, 32'h0000_0005, 10'd0,   10'd0);

        // Leaves beyond the old size must have kept their values
        set_size(11'd1024);
        send_item(segtree_pkg::OP_QUERY, 10'd0,    32'h0,         10'd0,   10'd1023);

        foreach (phase_sizes[p])
        begin
            set_size(phase_sizes[p]);
            repeat (163) random_item();
        end

        // Drain and settle
        @(negedge clk);
        start <= 1'b0;
        while (board.pending_sums.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("covered %0d checked queries, %0d leaf updates, %0d size settings",
                 board.n_checked, board.n_updates, n_settings);
        $display("mismatches: %0d", board.errors);
        if (board.errors == 0)
            $display("** segment_tree_point_add_range_sum: PASSED **");
        else
            $display("** segment_tree_point_add_range_sum: FAILED **");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/segtree_pkg.sv
rtl/segtree_ram.sv
rtl/segtree_engine.sv
rtl/segment_tree_point_add_range_sum.sv
verif/segment_tree_point_add_range_sum_tb.sv
